FILE: rtl/rmf_pkg.sv
`default_nettype none

package rmf_pkg;

   // sample and result width
   localparam int DATA_W = 16;

   // default build values
   localparam int WINDOW_DEF   = 7;
   localparam int SENTINEL_DEF = 0;

   // what one sort cell shows its neighbors
   typedef struct packed {
      logic              valid;  // cell holds a sample
      logic              up;     // new sample ranks above this cell's value
      logic [DATA_W-1:0] value;
   } link_type;

   // stand-in neighbor above the first cell: always holds, never moves
   localparam link_type HEAD_LINK = '{valid: 1'b1, up: 1'b0, value: '0};
   // stand-in neighbor below the last cell: empty
   localparam link_type TAIL_LINK = '{valid: 1'b0, up: 1'b1, value: '0};

endpackage

`default_nettype wire

FILE: rtl/rmf_stream_if.sv
`default_nettype none

// input channel: one sample per item
interface rmf_req_if import rmf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

// result channel: one median per item
interface rmf_rsp_if import rmf_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] median;

   modport source (output valid, output median, input ready);
   modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

FILE: rtl/rmf_delay_line.sv
`default_nettype none

module rmf_delay_line import rmf_pkg::*; #(
   parameter int DEPTH = WINDOW_DEF
) (
   input  wire logic              clock,
   input  wire logic              advance,
   input  wire logic [DATA_W-1:0] din,
   output logic      [DATA_W-1:0] oldest
);

   logic [DATA_W-1:0] tap_ff [DEPTH];

   // samples in arrival order, newest at tap 0
   always_ff @(posedge clock) begin
      if (advance) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   // sample that leaves the window on the next item
   assign oldest = tap_ff[DEPTH-1];

endmodule

`default_nettype wire

FILE: rtl/rmf_sort_cell.sv
`default_nettype none

module rmf_sort_cell import rmf_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              advance,
   input  wire logic              full,
   input  wire logic [DATA_W-1:0] sample,
   input  wire logic [DATA_W-1:0] oldest,
   input  wire link_type          prev_link,
   input  wire link_type          next_link,
   output link_type               link
);

   logic              valid_ff;
   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;
   logic              up_own;
   logic              keep_pos;
   logic              gone_above;
   logic              gone_here;
   logic [DATA_W-1:0] here_val;
   logic              here_up;
   logic [DATA_W-1:0] above_val;
   logic              above_up;

   // new sample goes above an empty cell or a smaller value
   assign up_own = !valid_ff || (sample > value_ff);

   // removed entry sits at or below this cell; while filling it is the first empty cell
   assign keep_pos   = full ? (value_ff >= oldest) : prev_link.valid;
   assign gone_above = !keep_pos;

   // removed entry is this cell: the last one not below the leaving sample
   assign gone_here = full && keep_pos && !(next_link.valid && (next_link.value >= oldest));

   // list after removal, at this position and the one above
   always_comb begin
      if (gone_here) begin
         here_val  = next_link.value;
         here_up   = next_link.up;
         above_val = prev_link.value;
         above_up  = prev_link.up;
      end else if (gone_above) begin
         here_val  = next_link.value;
         here_up   = next_link.up;
         above_val = value_ff;
         above_up  = up_own;
      end else begin
         here_val  = value_ff;
         here_up   = up_own;
         above_val = prev_link.value;
         above_up  = prev_link.up;
      end
   end

   // insert the new sample between the last value it does not beat and the rest
   always_comb begin
      if (!here_up) begin
         value_in = here_val;
      end else if (!above_up) begin
         value_in = sample;
      end else begin
         value_in = above_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= prev_link.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff <= value_in;
      end
   end

   assign link = '{valid: valid_ff, up: up_own, value: value_ff};

endmodule

`default_nettype wire

FILE: rtl/running_median_filter_top.sv
`default_nettype none

// a taken sample updates the sorted cell row; its result then leaves through the output register
// throughput: one item per cycle; the sorted cell row updates in the cycle the item is taken
// an item stalls only while a result waits in the cells behind a stalled output register
// reset: synchronous, empties all cells and the fill count; first results rank a partial window
// the sample history holds no reset and is read only once the window is full

module running_median_filter_top import rmf_pkg::*; #(
   parameter int WINDOW   = WINDOW_DEF,
   parameter int SENTINEL = SENTINEL_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rmf_req_if.sink    req_chan,
   rmf_rsp_if.source  rsp_chan
);

   localparam int CW = $clog2(WINDOW + 1);
   localparam int IW = $clog2(WINDOW);
   localparam logic [DATA_W-1:0] SENT_VAL = DATA_W'(SENTINEL);

   logic              req_fire;
   logic              out_free;
   logic [DATA_W-1:0] sample_fix;
   logic [DATA_W-1:0] oldest;
   logic              full;
   link_type          links [WINDOW];
   logic [WINDOW-1:0] valid_vec;

   logic [CW-1:0]     cnt_ff;
   logic [CW-1:0]     cnt_in;
   logic [IW-1:0]     mid_ff;
   logic              pend_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_median_ff;

   // handshake
   assign req_fire          = req_chan.valid && req_chan.ready;
   assign out_free          = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready    = !pend_ff || out_free;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.median   = rsp_median_ff;

   // sentinel sample ranks one above
   assign sample_fix = (req_chan.sample == SENT_VAL) ? (SENT_VAL + 1'b1) : req_chan.sample;

   // arrival-order history gives the sample to drop
   rmf_delay_line #(.DEPTH(WINDOW)) u_hist (
      .clock   (clock),
      .advance (req_fire),
      .din     (sample_fix),
      .oldest  (oldest)
   );

   assign full = links[WINDOW-1].valid;

   // sorted row, largest first
   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      link_type prev_l;
      link_type next_l;

      assign prev_l       = (i == 0) ? HEAD_LINK : links[(i == 0) ? 0 : i-1];
      assign next_l       = (i == WINDOW-1) ? TAIL_LINK : links[(i == WINDOW-1) ? i : i+1];
      assign valid_vec[i] = links[i].valid;

      rmf_sort_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (req_fire),
         .full      (full),
         .sample    (sample_fix),
         .oldest    (oldest),
         .prev_link (prev_l),
         .next_link (next_l),
         .link      (links[i])
      );
   end

   // fill count and the rank to read, settled with the item
   assign cnt_in = (cnt_ff == CW'(WINDOW)) ? cnt_ff : cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req_fire) begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         mid_ff <= IW'(cnt_in >> 1);
      end
   end

   // one item waits in the cells until the output register takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else if (req_fire) begin
         pend_ff <= 1'b1;
      end else if (out_free) begin
         pend_ff <= 1'b0;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && pend_ff) begin
         rsp_median_ff <= links[mid_ff].value;
      end
   end

   // checks
   a_fire_pends : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> pend_ff)
      else $error("taken item not pending");

   a_no_overrun : assert property (@(posedge clock) disable iff (reset)
      (pend_ff && !out_free) |-> !req_chan.ready)
      else $error("input open while result blocked");

   a_fill_count : assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(cnt_ff))
      else $error("cell fill does not match count");

   for (genvar j = 0; j < WINDOW-1; j++) begin : g_chk
      a_sorted : assert property (@(posedge clock) disable iff (reset)
         links[j+1].valid |-> (links[j].valid && links[j].value >= links[j+1].value))
         else $error("cell row out of order");
   end

endmodule

`default_nettype wire
